// ----- src/zswa_pkg.sv -----
// Shared types, sizes and reset constants for the zone-striped write allocator.
// No dependencies; imported by the allocator top level.
`default_nettype none

package zswa_pkg;

  // Geometry. ZONES_PER_NODE, NODES and their product with UNIT_SECTORS are powers of two:
  // a local zone index is {node, zone-in-node} and the stripe group splits by a shift.
  localparam int unsigned ZONES_PER_NODE = 4;
  localparam int unsigned UNIT_SECTORS   = 8;
  localparam int unsigned NODES          = 16;
  localparam int unsigned TOTAL_ZONES    = NODES * ZONES_PER_NODE;
  localparam int unsigned GROUP_SECTORS  = ZONES_PER_NODE * UNIT_SECTORS;

  // Field widths
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned NODE_IDX_W = 4;
  localparam int unsigned GZ_W       = 9;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned SEC_W      = 40;
  localparam int unsigned META_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;

  // Derived widths
  localparam int unsigned ZK_W       = $clog2(ZONES_PER_NODE);
  localparam int unsigned NODE_W     = $clog2(NODES);
  localparam int unsigned ZONE_W     = NODE_W + ZK_W;
  localparam int unsigned REM_W      = $clog2(GROUP_SECTORS);
  localparam int unsigned LEVEL_W    = CNT_W - REM_W;
  localparam int unsigned NODE_LIM_W = NODE_IDX_W + 1;

  // Register reset values
  localparam logic [SEC_W-1:0]  RESET_STRIDE   = 40'd524288;
  localparam logic [SEC_W-1:0]  RESET_CAPACITY = 40'd524288;
  localparam logic [META_W-1:0] RESET_META     = 8'd0;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_STRIDE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_CAPACITY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_METADATA_ZONES = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC    = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_RESET    = 2'd2,
    KIND_FINISH   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALLOC_RD,
    ST_ALLOC_END,
    ST_ALLOC_CHK,
    ST_ALLOC_FAIL,
    ST_ALLOC_UPD,
    ST_NODE_MUL,
    ST_NODE_WR,
    ST_CMPL_RD,
    ST_CMPL_WR
  } state_e;

  // Start sector of a local zone under the reset configuration
  function automatic logic [SEC_W-1:0] zone_reset_start(input logic [ZONE_W-1:0] zone);
    logic [SEC_W-1:0] gz;
    gz = SEC_W'(zone) + SEC_W'(RESET_META);
    zone_reset_start = SEC_W'(gz * RESET_STRIDE);
  endfunction

endpackage

`default_nettype wire

// ----- src/zswa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module zswa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- src/zone_striped_write_allocator_unit.sv -----
// Zone-striped write allocator: per-zone in-flight and write pointers in two RAMs.
// Depends on zswa_pkg and zswa_ram.
//
// Usage
//   Input channel (in_valid_i / in_stall_o) takes one request word: kind_i, node_index_i,
//   zone_number_i, sector_count_i. Output channel (out_valid_o / out_stall_i) returns
//   result words; last_o marks the final word of a request.
//   Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) are registered and must be
//   made only while the block is idle; the block itself does not enforce this.
// Sequencing
//   One request at a time. Allocate checks each zone in a read, end and check loop on the
//   in-flight pointer RAM, stopping at a refused zone, then writes back and emits one word
//   per cycle while the output register is free. Reset and finish: multiply, then write,
//   for each zone. Complete: read, then add and write back. Dropped: accepted, no word.
//   in_stall_o is high while one is busy.
// Reset
//   Configuration registers take their default values, all nodes are free and every pointer reads as
//   its zone start under the default configuration (per-entry valid bits, no clear pass).
// Back-pressure
//   Results wait in the output register while out_stall_i is high; the sequencer holds
//   the next word, and its RAM write, until the output register frees.
`default_nettype none

module zone_striped_write_allocator_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // request channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [zswa_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [zswa_pkg::NODE_IDX_W-1:0] node_index_i,
  input  wire logic [zswa_pkg::GZ_W-1:0]      zone_number_i,
  input  wire logic [zswa_pkg::CNT_W-1:0]     sector_count_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                status_o,
  output logic      [zswa_pkg::GZ_W-1:0]      out_zone_o,
  output logic      [zswa_pkg::SEC_W-1:0]     start_sector_o,
  output logic      [zswa_pkg::CNT_W-1:0]     stripe_sectors_o,
  output logic                                node_full_o,
  output logic                                last_o,
  // configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [zswa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [zswa_pkg::SEC_W-1:0]     cfg_data_i
);

  import zswa_pkg::*;

  // configuration registers
  logic [SEC_W-1:0]  stride_q;
  logic [SEC_W-1:0]  cap_q;
  logic [META_W-1:0] meta_q;

  // sequencer and request context
  state_e            state_q, state_d;
  kind_e             kind_q;
  logic [NODE_W-1:0] node_q;
  logic [ZK_W-1:0]   k_q;
  logic [CNT_W-1:0]  nsec_q;
  logic [REM_W-1:0]  rem_q;

  // per-zone working values
  logic [SEC_W-1:0]  mul_q;
  logic [SEC_W-1:0]  ip_q;
  logic [SEC_W:0]    end_q;
  logic [CNT_W-1:0]  grant_q;
  logic              any_full_q;
  logic [SEC_W-1:0]  ip_save_q    [ZONES_PER_NODE];
  logic [CNT_W-1:0]  grant_save_q [ZONES_PER_NODE];

  // valid bits for the pointer RAMs, node full flags
  logic [TOTAL_ZONES-1:0] ip_valid_q;
  logic [TOTAL_ZONES-1:0] wp_valid_q;
  logic [NODES-1:0]       node_full_q;

  // output register
  logic              out_valid_q;
  logic              out_status_q;
  logic [GZ_W-1:0]   out_zone_q;
  logic [SEC_W-1:0]  out_start_q;
  logic [CNT_W-1:0]  out_count_q;
  logic              out_full_q;
  logic              out_last_q;

  // combinational
  logic                   in_accept;
  logic                   out_free;
  logic [ZONE_W-1:0]      addr;
  logic [GZ_W-1:0]        gz;
  logic [SEC_W+GZ_W-1:0]  prod;
  logic [SEC_W-1:0]       ip_rdata, wp_rdata;
  logic [SEC_W-1:0]       ip_rd, wp_rd;
  logic [GZ_W:0]          cmpl_diff;
  logic                   cmpl_ok;
  logic                   node_ok;
  logic [LEVEL_W-1:0]     level;
  logic [REM_W-1:0]       take;
  logic [CNT_W-1:0]       grant_d;
  logic [SEC_W:0]         end_d;
  logic [SEC_W+1:0]       ip_sum;
  logic                   alloc_fail;
  logic                   zone_full;
  logic                   last_k;
  logic                   node_full_cur;
  logic [SEC_W-1:0]       save_sum;
  logic [SEC_W-1:0]       wp_sum;
  logic [SEC_W-1:0]       zone_end;

  logic                   emit;
  logic                   ip_we, wp_we;
  logic [SEC_W-1:0]       ip_wdata, wp_wdata;
  logic                   res_status;
  logic [SEC_W-1:0]       res_start;
  logic [CNT_W-1:0]       res_count;
  logic                   res_full;
  logic                   res_last;

  // ---------------------------------------------------------------------------
  // Pointer RAMs: both addressed by the current {node, zone-in-node}
  // ---------------------------------------------------------------------------
  assign addr = {node_q, k_q};

  zswa_ram #(
    .WIDTH (SEC_W),
    .DEPTH (TOTAL_ZONES)
  ) u_ip_ram (
    .clk_i   (clk_i),
    .we_i    (ip_we),
    .waddr_i (addr),
    .wdata_i (ip_wdata),
    .raddr_i (addr),
    .rdata_o (ip_rdata)
  );

  zswa_ram #(
    .WIDTH (SEC_W),
    .DEPTH (TOTAL_ZONES)
  ) u_wp_ram (
    .clk_i   (clk_i),
    .we_i    (wp_we),
    .waddr_i (addr),
    .wdata_i (wp_wdata),
    .raddr_i (addr),
    .rdata_o (wp_rdata)
  );

  // An entry never written reads as its zone start under the reset configuration.
  // The address holds between read issue and data use, so the valid bit lines up.
  assign ip_rd = ip_valid_q[addr] ? ip_rdata : zone_reset_start(addr);
  assign wp_rd = wp_valid_q[addr] ? wp_rdata : zone_reset_start(addr);

  // ---------------------------------------------------------------------------
  // Datapath arithmetic
  // ---------------------------------------------------------------------------
  assign gz   = GZ_W'(meta_q) + GZ_W'(addr);
  assign prod = gz * stride_q;

  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Complete: map the global zone to a local one, drop it when out of range
  assign cmpl_diff = {1'b0, zone_number_i} - (GZ_W + 1)'(meta_q);
  assign cmpl_ok   = !cmpl_diff[GZ_W] && (cmpl_diff[GZ_W-1:0] < GZ_W'(TOTAL_ZONES));
  assign node_ok   = ({1'b0, node_index_i} < NODE_LIM_W'(NODES));

  // Stripe split: whole units to every zone, the remainder a unit at a time in zone order
  assign level   = nsec_q[CNT_W-1:REM_W];
  assign take    = (rem_q >= REM_W'(UNIT_SECTORS)) ? REM_W'(UNIT_SECTORS) : rem_q;
  assign grant_d = CNT_W'(level * UNIT_SECTORS) + CNT_W'(take);

  // Zone end without wrap, for the space check
  assign end_d = {1'b0, mul_q} + {1'b0, cap_q};

  // Space check: refuse when a non-zero grant would pass the zone end
  assign ip_sum     = {2'b00, ip_q} + (SEC_W + 2)'(grant_q);
  assign alloc_fail = (grant_q != '0) && ((SEC_W + 2)'(end_q) < ip_sum);
  assign zone_full  = (end_q <= {1'b0, ip_sum[SEC_W-1:0]});

  assign last_k        = (k_q == ZK_W'(ZONES_PER_NODE - 1));
  assign node_full_cur = node_full_q[node_q];
  assign save_sum      = ip_save_q[k_q] + SEC_W'(grant_save_q[k_q]);
  assign wp_sum        = wp_rd + SEC_W'(nsec_q);
  assign zone_end      = mul_q + cap_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    emit       = 1'b0;
    ip_we      = 1'b0;
    wp_we      = 1'b0;
    ip_wdata   = save_sum;
    wp_wdata   = mul_q;
    res_status = 1'b0;
    res_start  = ip_q;
    res_count  = '0;
    res_full   = node_full_cur;
    res_last   = last_k;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (kind_e'(kind_i))
            KIND_COMPLETE: begin
              if (cmpl_ok) begin
                state_d = ST_CMPL_RD;
              end
            end
            KIND_ALLOC: begin
              if (node_ok) begin
                state_d = ST_ALLOC_RD;
              end
            end
            KIND_RESET, KIND_FINISH: begin
              if (node_ok) begin
                state_d = ST_NODE_MUL;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ALLOC_RD: begin
        state_d = ST_ALLOC_END;
      end
      ST_ALLOC_END: begin
        state_d = ST_ALLOC_CHK;
      end
      ST_ALLOC_CHK: begin
        if (alloc_fail) begin
          state_d = ST_ALLOC_FAIL;
        end else if (last_k) begin
          state_d = ST_ALLOC_UPD;
        end else begin
          state_d = ST_ALLOC_RD;
        end
      end
      ST_ALLOC_FAIL: begin
        // refuse: one word, no pointer moves
        if (out_free) begin
          emit       = 1'b1;
          res_status = 1'b1;
          res_start  = ip_q;
          res_last   = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_ALLOC_UPD: begin
        // write back each in-flight pointer together with its word
        if (out_free) begin
          emit      = 1'b1;
          ip_we     = 1'b1;
          ip_wdata  = save_sum;
          res_start = ip_save_q[k_q];
          res_count = grant_save_q[k_q];
          res_full  = node_full_cur || any_full_q;
          if (last_k) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_NODE_MUL: begin
        state_d = ST_NODE_WR;
      end
      ST_NODE_WR: begin
        if (out_free) begin
          emit  = 1'b1;
          wp_we = 1'b1;
          if (kind_q == KIND_RESET) begin
            ip_we     = 1'b1;
            ip_wdata  = mul_q;
            wp_wdata  = mul_q;
            res_start = mul_q;
            res_full  = 1'b0;
          end else begin
            wp_wdata  = zone_end;
            res_start = zone_end;
          end
          state_d = last_k ? ST_IDLE : ST_NODE_MUL;
        end
      end
      ST_CMPL_RD: begin
        state_d = ST_CMPL_WR;
      end
      ST_CMPL_WR: begin
        if (out_free) begin
          emit      = 1'b1;
          wp_we     = 1'b1;
          wp_wdata  = wp_sum;
          res_start = wp_sum;
          res_count = nsec_q;
          res_last  = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Request context and per-zone working registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          kind_q     <= kind_e'(kind_i);
          nsec_q     <= sector_count_i;
          rem_q      <= sector_count_i[REM_W-1:0];
          any_full_q <= 1'b0;
          if (kind_i == KIND_COMPLETE) begin
            node_q <= cmpl_diff[ZONE_W-1:ZK_W];
            k_q    <= cmpl_diff[ZK_W-1:0];
          end else begin
            node_q <= node_index_i[NODE_W-1:0];
            k_q    <= '0;
          end
        end
      end
      ST_ALLOC_RD, ST_NODE_MUL: begin
        mul_q <= prod[SEC_W-1:0];
      end
      ST_ALLOC_END: begin
        ip_q    <= ip_rd;
        end_q   <= end_d;
        grant_q <= grant_d;
        rem_q   <= rem_q - take;
      end
      ST_ALLOC_CHK: begin
        if (!alloc_fail) begin
          ip_save_q[k_q]    <= ip_q;
          grant_save_q[k_q] <= grant_q;
          any_full_q        <= any_full_q || zone_full;
          k_q               <= last_k ? '0 : k_q + 1'b1;
        end
      end
      ST_ALLOC_UPD, ST_NODE_WR: begin
        if (out_free) begin
          k_q <= last_k ? '0 : k_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Valid bits, node state, output handshake
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip_valid_q  <= '0;
      wp_valid_q  <= '0;
      node_full_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ip_we) begin
        ip_valid_q[addr] <= 1'b1;
      end
      if (wp_we) begin
        wp_valid_q[addr] <= 1'b1;
      end
      // mark full after a granted allocation that fills a zone, free on node reset
      if ((state_q == ST_ALLOC_UPD) && out_free && last_k && any_full_q) begin
        node_full_q[node_q] <= 1'b1;
      end
      if ((state_q == ST_NODE_WR) && out_free && last_k && (kind_q == KIND_RESET)) begin
        node_full_q[node_q] <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= res_status;
      out_zone_q   <= gz;
      out_start_q  <= res_start;
      out_count_q  <= res_count;
      out_full_q   <= res_full;
      out_last_q   <= res_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign out_zone_o       = out_zone_q;
  assign start_sector_o   = out_start_q;
  assign stripe_sectors_o = out_count_q;
  assign node_full_o      = out_full_q;
  assign last_o           = out_last_q;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= RESET_STRIDE;
      cap_q    <= RESET_CAPACITY;
      meta_q   <= RESET_META;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ZONE_STRIDE:    stride_q <= cfg_data_i;
        CFG_ZONE_CAPACITY:  cap_q    <= cfg_data_i;
        CFG_METADATA_ZONES: meta_q   <= cfg_data_i[META_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
